// ----- sv/bbht_pkg.sv -----
`default_nettype none

package bbht_pkg;

   localparam int KEY_W    = 20;
   localparam int VALUE_W  = 16;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int BKT_OUT_W = 4;

   typedef logic [OP_W-1:0]      op_type;
   typedef logic [KEY_W-1:0]     key_type;
   typedef logic [VALUE_W-1:0]   value_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [BKT_OUT_W-1:0] bkt_out_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_MODIFY = 2'd2;
   localparam op_type OP_SEARCH = 2'd3;

   localparam status_type ST_DONE     = 2'd0;
   localparam status_type ST_DUP      = 2'd1;
   localparam status_type ST_NOTFOUND = 2'd2;
   localparam status_type ST_FULL     = 2'd3;

   // One slot of a bucket row as it sits in the table memory.
   typedef struct packed {
      logic      valid;
      key_type   key;
      value_type value;
   } slot_type;

endpackage

`default_nettype wire

// ----- sv/bbht_req_if.sv -----
`default_nettype none

interface bbht_req_if;
   import bbht_pkg::*;

   logic      valid;
   logic      ready;
   op_type    req_type;
   key_type   emp_id;
   value_type leave_value;

   modport source (output valid, req_type, emp_id, leave_value, input ready);
   modport sink   (input valid, req_type, emp_id, leave_value, output ready);

endinterface

`default_nettype wire

// ----- sv/bbht_rsp_if.sv -----
`default_nettype none

interface bbht_rsp_if;
   import bbht_pkg::*;

   logic        valid;
   logic        ready;
   status_type  status;
   value_type   read_value;
   bkt_out_type bucket_used;

   modport source (output valid, status, read_value, bucket_used, input ready);
   modport sink   (input valid, status, read_value, bucket_used, output ready);

endinterface

`default_nettype wire

// ----- sv/bbht_ram.sv -----
`default_nettype none

module bbht_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/bounded_bucket_hash_table_top.sv -----
// Channel   Port      Direction  Beat contents
// -------   --------  ---------  -----------------------------------------
// request   req_chan  in         req_type, emp_id, leave_value
// response  rsp_chan  out        status, read_value, bucket_used
//
// Each accepted request steps through the hash, scan and fetch states, the write-back
// state when an insert, remove or modify changes the table, and the result state that
// offers the response beat. The scan reads every bucket, one row per cycle, from the
// single table RAM. After reset the RAM is cleared one row per cycle, so no request is
// accepted until every row is cleared. A stalled response does not block the next
// request; only the next response waits for the output register.
`default_nettype none

module bounded_bucket_hash_table_top #(
   parameter int BUCKETS = 16,
   parameter int WAYS    = 4
) (
   input wire logic  clock,
   input wire logic  reset,
   bbht_req_if.sink  req_chan,
   bbht_rsp_if.source rsp_chan
);
   import bbht_pkg::*;

   // Bucket number width, way number width and the row layout of the table.
   localparam int BW = $clog2(BUCKETS);
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef slot_type [WAYS-1:0] row_type;
   localparam int ROW_W = $bits(row_type);

   // The home bucket is key mod BUCKETS, computed with a reciprocal. The quotient
   // estimate is the true quotient or one below it, so one conditional subtract
   // fixes the remainder.
   localparam int RECIP_SHIFT = KEY_W + 8;
   localparam int PROD_W      = KEY_W + RECIP_SHIFT;
   localparam int REM_W       = KEY_W + 1;
   localparam logic [RECIP_SHIFT-1:0] RECIP =
      RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / BUCKETS);
   localparam logic [REM_W-1:0] BUCKETS_REM = REM_W'(BUCKETS);
   localparam logic [BW:0]      BUCKETS_CNT = (BW+1)'(BUCKETS);
   localparam logic [BW-1:0]    LAST_BKT    = BW'(BUCKETS - 1);

   // Sequencer states.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_FETCH  = 3'd4;
   localparam logic [2:0] S_MODIFY = 3'd5;
   localparam logic [2:0] S_RESULT = 3'd6;

   logic [2:0] state_ff, state_in;

   // Request held for the whole operation.
   op_type    op_ff, op_in;
   key_type   key_ff, key_in;
   value_type val_ff, val_in;

   // Home bucket computation.
   logic [PROD_W-1:0] prod;
   key_type           q_ff, q_in;
   logic [REM_W-1:0]  qb, rem_raw, rem_fix;
   logic [BW-1:0]     home_ff, home_in;

   // Scan control: scan_ff issues row reads, chk_* marks the row on the RAM output.
   logic [BW:0]   scan_ff, scan_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [BW-1:0] chk_bkt_ff, chk_bkt_in;
   logic [BW-1:0] clr_ff, clr_in;

   // What the scan found: the key, and the first non-full bucket at or after
   // home (hi) and the first non-full bucket overall (lo) for the wrap-around.
   logic          hit_ff, hit_in;
   logic [BW-1:0] hit_bkt_ff, hit_bkt_in;
   logic [WW-1:0] hit_way_ff, hit_way_in;
   value_type     hit_val_ff, hit_val_in;
   logic          hi_ff, hi_in;
   logic [BW-1:0] hi_bkt_ff, hi_bkt_in;
   logic [WW-1:0] hi_way_ff, hi_way_in;
   logic          lo_ff, lo_in;
   logic [BW-1:0] lo_bkt_ff, lo_bkt_in;
   logic [WW-1:0] lo_way_ff, lo_way_in;

   // Row to be rewritten.
   logic [BW-1:0] tgt_bkt_ff, tgt_bkt_in;
   logic [WW-1:0] tgt_way_ff, tgt_way_in;

   // Finished result, and the output register.
   status_type    res_status_ff, res_status_in;
   value_type     res_value_ff, res_value_in;
   logic [BW-1:0] res_bkt_ff, res_bkt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   value_type     rsp_value_ff, rsp_value_in;
   bkt_out_type   rsp_bkt_ff, rsp_bkt_in;

   // Table RAM port signals.
   logic             ram_we, ram_re;
   logic [BW-1:0]    ram_waddr, ram_raddr;
   logic [ROW_W-1:0] ram_wdata, ram_rdata;
   row_type          row_rd, row_wr;

   // Per-way decode of the row on the RAM output.
   logic [WAYS-1:0] match_w, free_w;
   logic [WW-1:0]   match_way, free_way;

   bbht_ram #(
      .Width (ROW_W),
      .Depth (BUCKETS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign row_rd = row_type'(ram_rdata);

   // The lowest matching and the lowest free way of the row being checked.
   always_comb begin
      match_way = '0;
      free_way  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         match_w[w] = row_rd[w].valid && (row_rd[w].key == key_ff);
         free_w[w]  = !row_rd[w].valid;
         if (match_w[w]) begin
            match_way = WW'(w);
         end
         if (free_w[w]) begin
            free_way = WW'(w);
         end
      end
   end

   // Home bucket arithmetic: one multiply in HASH, multiply-subtract in the first
   // scan cycle, so home_ff is ready when the first row comes back.
   assign prod    = PROD_W'(key_ff) * PROD_W'(RECIP);
   assign qb      = REM_W'(q_ff) * BUCKETS_REM;
   assign rem_raw = REM_W'(key_ff) - qb;
   assign rem_fix = (rem_raw >= BUCKETS_REM) ? (rem_raw - BUCKETS_REM) : rem_raw;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      q_in          = q_ff;
      home_in       = home_ff;
      scan_in       = scan_ff;
      chk_vld_in    = 1'b0;
      chk_bkt_in    = scan_ff[BW-1:0];
      clr_in        = clr_ff;
      hit_in        = hit_ff;
      hit_bkt_in    = hit_bkt_ff;
      hit_way_in    = hit_way_ff;
      hit_val_in    = hit_val_ff;
      hi_in         = hi_ff;
      hi_bkt_in     = hi_bkt_ff;
      hi_way_in     = hi_way_ff;
      lo_in         = lo_ff;
      lo_bkt_in     = lo_bkt_ff;
      lo_way_in     = lo_way_ff;
      tgt_bkt_in    = tgt_bkt_ff;
      tgt_way_in    = tgt_way_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_bkt_in    = res_bkt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_bkt_in    = rsp_bkt_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_ff;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = scan_ff[BW-1:0];
      row_wr        = row_rd;

      // Check the row that the previous scan cycle read. Keys are unique, so at
      // most one bucket can hit.
      if (chk_vld_ff) begin
         if (|match_w && !hit_ff) begin
            hit_in     = 1'b1;
            hit_bkt_in = chk_bkt_ff;
            hit_way_in = match_way;
            hit_val_in = row_rd[match_way].value;
         end
         if (|free_w && !lo_ff) begin
            lo_in     = 1'b1;
            lo_bkt_in = chk_bkt_ff;
            lo_way_in = free_way;
         end
         if (|free_w && !hi_ff && (chk_bkt_ff >= home_ff)) begin
            hi_in     = 1'b1;
            hi_bkt_in = chk_bkt_ff;
            hi_way_in = free_way;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            // Zero one row per cycle so every slot starts out free.
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (clr_ff == LAST_BKT) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.req_type;
               key_in   = req_chan.emp_id;
               val_in   = req_chan.leave_value;
               scan_in  = '0;
               hit_in   = 1'b0;
               hi_in    = 1'b0;
               lo_in    = 1'b0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            q_in     = prod[PROD_W-1:RECIP_SHIFT];
            state_in = S_SCAN;
         end
         S_SCAN: begin
            home_in = rem_fix[BW-1:0];
            if (scan_ff < BUCKETS_CNT) begin
               ram_re     = 1'b1;
               ram_raddr  = scan_ff[BW-1:0];
               chk_vld_in = 1'b1;
               scan_in    = scan_ff + 1'b1;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            res_value_in = '0;
            res_bkt_in   = '0;
            if (op_ff == OP_INSERT) begin
               if (hit_ff) begin
                  res_status_in = ST_DUP;
                  res_bkt_in    = hit_bkt_ff;
                  state_in      = S_RESULT;
               end else if (hi_ff) begin
                  tgt_bkt_in = hi_bkt_ff;
                  tgt_way_in = hi_way_ff;
                  ram_re     = 1'b1;
                  ram_raddr  = hi_bkt_ff;
                  state_in   = S_MODIFY;
               end else if (lo_ff) begin
                  // Wrapped past the last bucket.
                  tgt_bkt_in = lo_bkt_ff;
                  tgt_way_in = lo_way_ff;
                  ram_re     = 1'b1;
                  ram_raddr  = lo_bkt_ff;
                  state_in   = S_MODIFY;
               end else begin
                  res_status_in = ST_FULL;
                  state_in      = S_RESULT;
               end
            end else if (!hit_ff) begin
               res_status_in = ST_NOTFOUND;
               state_in      = S_RESULT;
            end else if (op_ff == OP_SEARCH) begin
               res_status_in = ST_DONE;
               res_value_in  = hit_val_ff;
               res_bkt_in    = hit_bkt_ff;
               state_in      = S_RESULT;
            end else begin
               tgt_bkt_in = hit_bkt_ff;
               tgt_way_in = hit_way_ff;
               ram_re     = 1'b1;
               ram_raddr  = hit_bkt_ff;
               state_in   = S_MODIFY;
            end
         end
         S_MODIFY: begin
            // The target row is on the RAM output; change one slot and write back.
            case (op_ff)
               OP_INSERT: begin
                  row_wr[tgt_way_ff].valid = 1'b1;
                  row_wr[tgt_way_ff].key   = key_ff;
                  row_wr[tgt_way_ff].value = val_ff;
               end
               OP_REMOVE: begin
                  row_wr[tgt_way_ff].valid = 1'b0;
               end
               default: begin
                  row_wr[tgt_way_ff].value = val_ff;
               end
            endcase
            ram_we        = 1'b1;
            ram_waddr     = tgt_bkt_ff;
            ram_wdata     = ROW_W'(row_wr);
            res_status_in = ST_DONE;
            res_bkt_in    = tgt_bkt_ff;
            state_in      = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_bkt_in    = bkt_out_type'(res_bkt_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      q_ff          <= q_in;
      home_ff       <= home_in;
      scan_ff       <= scan_in;
      chk_bkt_ff    <= chk_bkt_in;
      hit_ff        <= hit_in;
      hit_bkt_ff    <= hit_bkt_in;
      hit_way_ff    <= hit_way_in;
      hit_val_ff    <= hit_val_in;
      hi_ff         <= hi_in;
      hi_bkt_ff     <= hi_bkt_in;
      hi_way_ff     <= hi_way_in;
      lo_ff         <= lo_in;
      lo_bkt_ff     <= lo_bkt_in;
      lo_way_ff     <= lo_way_in;
      tgt_bkt_ff    <= tgt_bkt_in;
      tgt_way_ff    <= tgt_way_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_bkt_ff    <= res_bkt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_bkt_ff    <= rsp_bkt_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.bucket_used = rsp_bkt_ff;

   // A new response beat is only ever loaded by the result state.
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_chan.ready)) |->
         $past(state_ff) == S_RESULT)
      else $error("response appeared outside the result state");

   // An insert must land in a free slot, never overwrite a live record.
   a_insert_free_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODIFY && op_ff == OP_INSERT) |-> !row_rd[tgt_way_ff].valid)
      else $error("insert targets an occupied slot");

   // The table RAM is never read and written at the same row in one cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("table RAM read and write collide");

   // Only a successful search returns a nonzero value.
   a_value_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.read_value != '0) |-> rsp_chan.status == ST_DONE)
      else $error("nonzero read_value on a failed request");

endmodule

`default_nettype wire

// ----- tb/tb_bounded_bucket_hash_table_top.sv -----
`default_nettype none

module tb_bounded_bucket_hash_table_top;
   import bbht_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Table geometry; the DUT is built with the same figures.
   localparam int BUCKETS = 16;
   localparam int WAYS    = 4;
   localparam int SLOTS   = BUCKETS * WAYS;

   // Shape of the random part. Each round fills the table past capacity from a
   // pool of fresh keys, stirs it with mixed traffic, then empties it again.
   localparam int ROUNDS      = 5;
   localparam int POOL        = 80;
   localparam int FILL_ITEMS  = 90;
   localparam int MIX_ITEMS   = 40;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 300000;

   // One response beat, field for field.
   typedef struct packed {
      status_type  status;
      value_type   read_value;
      bkt_out_type bucket_used;
   } reply_type;

   // One row of the directed table. When fixed is set, the reply is typed in
   // by hand; otherwise it comes from the table mirror below.
   typedef struct {
      op_type    op;
      key_type   key;
      value_type value;
      bit        fixed;
      reply_type reply;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bbht_req_if req_bus ();
   bbht_rsp_if rsp_bus ();

   bounded_bucket_hash_table_top #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Mirror of the slot array, kept in step with every accepted request.
   bit        mirror_valid [SLOTS];
   key_type   mirror_key   [SLOTS];
   value_type mirror_value [SLOTS];

   // Replies owed by the DUT, oldest first.
   reply_type replies_due [$];

   int mismatches  = 0;
   int cycle_count = 0;

   // Idle controls shared between the stimulus and the response side. The
   // stimulus asks for a long response hold by bumping hold_asked.
   bit src_idle    = 1'b1;
   bit sink_idle   = 1'b1;
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;
   int stall_left  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the mirror and returns the reply the DUT owes.
   // Lookups scan every slot in order, so the lowest matching slot wins; keys
   // are unique, so there is at most one.
   function automatic reply_type table_apply(op_type op, key_type k, value_type v);
      reply_type r;
      int        hit;
      int        free_slot;
      int        b;
      r = '{ST_NOTFOUND, '0, '0};
      hit = -1;
      free_slot = -1;
      for (int s = 0; s < SLOTS; s++) begin
         if (hit < 0 && mirror_valid[s] && mirror_key[s] == k) hit = s;
      end
      if (op == OP_INSERT) begin
         if (hit >= 0) begin
            r.status = ST_DUP;
            r.bucket_used = bkt_out_type'(hit / WAYS);
         end else begin
            // Home bucket first, then onward with wrap until a free way shows up.
            for (int i = 0; i < BUCKETS && free_slot < 0; i++) begin
               b = (int'(k % BUCKETS) + i) % BUCKETS;
               for (int w = 0; w < WAYS; w++) begin
                  if (free_slot < 0 && !mirror_valid[b * WAYS + w]) begin
                     free_slot = b * WAYS + w;
                     r.bucket_used = bkt_out_type'(b);
                  end
               end
            end
            if (free_slot >= 0) begin
               mirror_valid[free_slot] = 1'b1;
               mirror_key[free_slot]   = k;
               mirror_value[free_slot] = v;
               r.status = ST_DONE;
            end else begin
               r.status = ST_FULL;
               r.bucket_used = '0;
            end
         end
      end else if (hit >= 0) begin
         r.status = ST_DONE;
         r.bucket_used = bkt_out_type'(hit / WAYS);
         case (op)
            OP_REMOVE: mirror_valid[hit] = 1'b0;
            OP_MODIFY: mirror_value[hit] = v;
            default:   r.read_value = mirror_value[hit];
         endcase
      end
      return r;
   endfunction

   // Values lean toward the two extremes now and then.
   function automatic value_type pick_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return value_type'($urandom);
      endcase
   endfunction

   // Offers one request beat and waits until it is taken. The mirror is
   // updated at the accepting edge, so it always reflects every beat that the
   // DUT has already taken. A fixed reply, when given, replaces the mirror's.
   task automatic send_request(input op_type op, input key_type k, input value_type v,
                               input bit fixed, input reply_type fixed_reply);
      reply_type predicted;
      if (src_idle && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= op;
      req_bus.emp_id      <= k;
      req_bus.leave_value <= v;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = table_apply(op, k, v);
      replies_due.push_back(fixed ? fixed_reply : predicted);
   endtask

   // Response side: a long hold when asked for, random short stalls while
   // sink_idle is set, and ready high otherwise. Every stall is counted in
   // cycles here, independent of what the sender is doing.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Every response beat is matched against the oldest reply owed.
   always @(posedge clock) begin
      reply_type owed;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (replies_due.size() == 0) begin
            $display("%0t: response beat with no request pending: status %0d value %h bucket %0d",
                     $time, rsp_bus.status, rsp_bus.read_value, rsp_bus.bucket_used);
            mismatches++;
         end else begin
            owed = replies_due.pop_front();
            if (rsp_bus.status !== owed.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, owed.status, rsp_bus.status);
               mismatches++;
            end
            if (rsp_bus.read_value !== owed.read_value) begin
               $display("%0t: read_value expected %h actual %h",
                        $time, owed.read_value, rsp_bus.read_value);
               mismatches++;
            end
            if (rsp_bus.bucket_used !== owed.bucket_used) begin
               $display("%0t: bucket_used expected %0d actual %0d",
                        $time, owed.bucket_used, rsp_bus.bucket_used);
               mismatches++;
            end
         end
      end
   end

   // Watchdog. The limit is several times the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      dir_row_type directed [$];
      key_type     pool [POOL];
      key_type     live [$];
      key_type     k;
      key_type     tmp;
      int          mode;
      int          home_a;
      int          home_b;
      int          next_ins;
      int          pick;
      int          j;

      // Directed part. The hand-typed replies are the obvious ones: an empty
      // table, keys at the ends of the range, a duplicate insert and misses.
      // The rows in between fill the top bucket so that an insert wraps
      // around into bucket zero; those are left to the mirror.
      directed = '{
         '{OP_SEARCH, 20'h00000, 16'h0000, 1'b1, '{ST_NOTFOUND, 16'h0000, 4'd0}},
         '{OP_REMOVE, 20'hFFFFF, 16'hFFFF, 1'b1, '{ST_NOTFOUND, 16'h0000, 4'd0}},
         '{OP_MODIFY, 20'h12345, 16'hFFFF, 1'b1, '{ST_NOTFOUND, 16'h0000, 4'd0}},
         '{OP_INSERT, 20'h00000, 16'hFFFF, 1'b1, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_INSERT, 20'hFFFFF, 16'h0000, 1'b1, '{ST_DONE,     16'h0000, 4'd15}},
         '{OP_INSERT, 20'h00000, 16'h1234, 1'b1, '{ST_DUP,      16'h0000, 4'd0}},
         '{OP_SEARCH, 20'h00000, 16'h0000, 1'b1, '{ST_DONE,     16'hFFFF, 4'd0}},
         '{OP_SEARCH, 20'hFFFFF, 16'hFFFF, 1'b1, '{ST_DONE,     16'h0000, 4'd15}},
         '{OP_MODIFY, 20'hFFFFF, 16'hA5A5, 1'b1, '{ST_DONE,     16'h0000, 4'd15}},
         '{OP_SEARCH, 20'hFFFFF, 16'h0000, 1'b1, '{ST_DONE,     16'hA5A5, 4'd15}},
         '{OP_INSERT, 20'h0001F, 16'h1111, 1'b0, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_INSERT, 20'h0002F, 16'h2222, 1'b0, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_INSERT, 20'h0003F, 16'h3333, 1'b0, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_INSERT, 20'h0004F, 16'h4444, 1'b0, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_SEARCH, 20'h0004F, 16'h0000, 1'b0, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_INSERT, 20'h8000F, 16'h8000, 1'b0, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_REMOVE, 20'h00000, 16'h5555, 1'b1, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_SEARCH, 20'h00000, 16'h0000, 1'b1, '{ST_NOTFOUND, 16'h0000, 4'd0}},
         '{OP_REMOVE, 20'h00000, 16'h0000, 1'b1, '{ST_NOTFOUND, 16'h0000, 4'd0}},
         '{OP_INSERT, 20'h0004F, 16'h9999, 1'b0, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_MODIFY, 20'h0004F, 16'h0000, 1'b0, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_SEARCH, 20'h0004F, 16'hFFFF, 1'b0, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_REMOVE, 20'h0004F, 16'h0000, 1'b0, '{ST_DONE,     16'h0000, 4'd0}},
         '{OP_SEARCH, 20'h8000F, 16'h0000, 1'b0, '{ST_DONE,     16'h0000, 4'd0}}
      };

      // Every input starts at a known value; the DUT sits in reset, then clears
      // its table before it takes the first beat.
      req_bus.valid       <= 1'b0;
      req_bus.req_type    <= OP_INSERT;
      req_bus.emp_id      <= '0;
      req_bus.leave_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_request(directed[i].op, directed[i].key, directed[i].value,
                      directed[i].fixed, directed[i].reply);
      end

      for (int round = 0; round < ROUNDS; round++) begin
         // Idle pattern per round: both sides idling, receiver-only, sender-only,
         // and a final round with no idling at all.
         src_idle  = (round != 1) && (round != ROUNDS - 1);
         sink_idle = (round != 3) && (round != ROUNDS - 1);

         // Fresh keys. Mode 0 spreads them over all buckets, mode 1 piles them
         // onto two home buckets, mode 2 onto a single one, which forces long
         // overflow chains with wrap-around.
         mode   = $urandom_range(0, 2);
         home_a = $urandom_range(0, BUCKETS - 1);
         home_b = $urandom_range(0, BUCKETS - 1);
         for (int p = 0; p < POOL; p++) begin
            k = key_type'($urandom);
            if (mode == 1) begin
               k = k - key_type'(k % BUCKETS) + key_type'($urandom_range(0, 1) ? home_a : home_b);
            end else if (mode == 2) begin
               k = k - key_type'(k % BUCKETS) + key_type'(home_a);
            end
            pool[p] = k;
         end

         // Fill: mostly new inserts, so the table runs full well before the
         // pool runs out, with lookups, duplicates and stray keys mixed in.
         next_ins = 0;
         for (int i = 0; i < FILL_ITEMS; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 8 && next_ins < POOL) begin
               send_request(OP_INSERT, pool[next_ins], pick_value(), 1'b0, '0);
               next_ins++;
            end else if (pick < 9) begin
               send_request(op_type'($urandom_range(0, 3)), pool[$urandom_range(0, POOL - 1)],
                            pick_value(), 1'b0, '0);
            end else begin
               send_request(op_type'($urandom_range(0, 3)), key_type'($urandom),
                            pick_value(), 1'b0, '0);
            end
         end

         // In the second round the receiver stops for a long while here, so
         // the response register and then the request side back up.
         if (round == 1) hold_asked++;

         for (int i = 0; i < MIX_ITEMS; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               k = key_type'($urandom);
            end else begin
               k = pool[$urandom_range(0, POOL - 1)];
            end
            send_request(op_type'($urandom_range(0, 3)), k, pick_value(), 1'b0, '0);
         end

         // Drain: remove every key the table holds, in shuffled order, with a
         // few lookups of pool keys in between.
         live.delete();
         for (int s = 0; s < SLOTS; s++) begin
            if (mirror_valid[s]) live.push_back(mirror_key[s]);
         end
         for (int i = live.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = live[i];
            live[i] = live[j];
            live[j] = tmp;
         end
         foreach (live[i]) begin
            if ($urandom_range(0, 3) == 0) begin
               send_request($urandom_range(0, 1) ? OP_SEARCH : OP_MODIFY,
                            pool[$urandom_range(0, POOL - 1)], pick_value(), 1'b0, '0);
            end
            send_request(OP_REMOVE, live[i], pick_value(), 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;

      // Wait for every owed reply, then a little longer to catch stray beats.
      while (replies_due.size() != 0) @(posedge clock);
      repeat (BUCKETS + 10) @(posedge clock);

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
